[rtl/core/sdes_pkg.sv]
// Shared types and constants for the stick deadzone and edge scaler.
// Used by the top level; depends on nothing else.
package sdes_pkg;

  // Axis sample and fraction widths.
  localparam int AXIS_W = 16;
  localparam int LEVEL_W = 15;
  localparam int NUM_W = 16;            // magnitude above the deadzone, up to 32768
  localparam int FRAC_W = 32;           // first quotient, Q16 with up to 16 integer bits
  localparam int LIM_W = 17;            // limited fraction, at most one (Q16)
  localparam int QBITS = 16;            // fractional bits of every fraction

  // One in Q16.
  localparam logic [FRAC_W-1:0] QONE = 32'h0001_0000;
  localparam logic [LIM_W-1:0] QONE_LIM = 17'h1_0000;

  // Register reset values.
  localparam logic [LEVEL_W-1:0] DEAD_RESET = 15'h0000;
  localparam logic [LEVEL_W-1:0] EDGE_RESET = 15'h7FFF;

  // Register select, taken from paddr[2].
  localparam logic REG_DEAD = 1'b0;
  localparam logic REG_EDGE = 1'b1;

  // Sideband that travels with a request through the first divider chain.
  typedef struct packed {
    logic              bypass;
    logic [AXIS_W-1:0] raw_x;
    logic [AXIS_W-1:0] raw_y;
  } side1_t;

  // Sideband that travels with a request through the limiting divider chain.
  typedef struct packed {
    side1_t           base;
    logic             lim;
    logic             x_max;
    logic [LIM_W-1:0] fx;
    logic [LIM_W-1:0] fy;
  } side2_t;

endpackage

[rtl/core/sdes_div_cell.sv]
// One restoring division step with an output register, for one or more lanes.
// Stand-alone; chained by sdes_div_chain.
module sdes_div_cell #(
  parameter int LANES  = 2,
  parameter int DVS_W  = 15,
  parameter int STEPS  = 32,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  input  logic [SIDE_W-1:0]                 side_i,
  input  logic [LANES-1:0][DVS_W-1:0]       dvs_i,
  input  logic [LANES-1:0][DVS_W-1:0]       rem_i,
  input  logic [LANES-1:0][STEPS-1:0]       dvd_i,
  input  logic [LANES-1:0][STEPS-1:0]       quo_i,
  output logic                              vld_o,
  output logic [SIDE_W-1:0]                 side_o,
  output logic [LANES-1:0][DVS_W-1:0]       dvs_o,
  output logic [LANES-1:0][DVS_W-1:0]       rem_o,
  output logic [LANES-1:0][STEPS-1:0]       dvd_o,
  output logic [LANES-1:0][STEPS-1:0]       quo_o
);

  logic                        vld_r;
  logic [SIDE_W-1:0]           side_r;
  logic [LANES-1:0][DVS_W-1:0] dvs_r;
  logic [LANES-1:0][DVS_W-1:0] rem_r;
  logic [LANES-1:0][STEPS-1:0] dvd_r;
  logic [LANES-1:0][STEPS-1:0] quo_r;

  logic [LANES-1:0][DVS_W-1:0] rem_nxt;
  logic [LANES-1:0][STEPS-1:0] dvd_nxt;
  logic [LANES-1:0][STEPS-1:0] quo_nxt;
  logic [LANES-1:0][DVS_W:0]   trial;
  logic [LANES-1:0][DVS_W:0]   diff;
  logic [LANES-1:0]            fits;

  // Shift the next dividend bit into the remainder and subtract where it fits.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l]   = {rem_i[l], dvd_i[l][STEPS-1]};
      fits[l]    = trial[l] >= {1'b0, dvs_i[l]};
      diff[l]    = trial[l] - {1'b0, dvs_i[l]};
      rem_nxt[l] = fits[l] ? diff[l][DVS_W-1:0] : trial[l][DVS_W-1:0];
      dvd_nxt[l] = {dvd_i[l][STEPS-2:0], 1'b0};
      quo_nxt[l] = {quo_i[l][STEPS-2:0], fits[l]};
    end
  end

  // Request valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // Payload moves on every cycle.
  always_ff @(posedge clk) begin
    side_r <= side_i;
    dvs_r  <= dvs_i;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign dvs_o  = dvs_r;
  assign rem_o  = rem_r;
  assign dvd_o  = dvd_r;
  assign quo_o  = quo_r;

endmodule

[rtl/core/sdes_div_chain.sv]
// Pipelined divider: a row of sdes_div_cell stages, one quotient bit per stage.
// Depends on sdes_div_cell.
module sdes_div_chain #(
  parameter int LANES  = 2,
  parameter int DVS_W  = 15,
  parameter int STEPS  = 32,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  input  logic [SIDE_W-1:0]                 side_i,
  input  logic [LANES-1:0][DVS_W-1:0]       dvs_i,
  input  logic [LANES-1:0][DVS_W-1:0]       rem_i,
  input  logic [LANES-1:0][STEPS-1:0]       dvd_i,
  output logic                              vld_o,
  output logic [SIDE_W-1:0]                 side_o,
  output logic [LANES-1:0][STEPS-1:0]       quo_o
);

  logic [STEPS:0]                              vld;
  logic [STEPS:0][SIDE_W-1:0]                  side;
  logic [STEPS:0][LANES-1:0][DVS_W-1:0]        dvs;
  logic [STEPS:0][LANES-1:0][DVS_W-1:0]        rem;
  logic [STEPS:0][LANES-1:0][STEPS-1:0]        dvd;
  logic [STEPS:0][LANES-1:0][STEPS-1:0]        quo;

  // Chain entry: the quotient starts empty.
  assign vld[0]  = vld_i;
  assign side[0] = side_i;
  assign dvs[0]  = dvs_i;
  assign rem[0]  = rem_i;
  assign dvd[0]  = dvd_i;
  assign quo[0]  = '0;

  // One cell for each quotient bit, most significant first.
  for (genvar s = 0; s < STEPS; s++) begin : g_cell
    sdes_div_cell #(
      .LANES  (LANES),
      .DVS_W  (DVS_W),
      .STEPS  (STEPS),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld[s]),
      .side_i (side[s]),
      .dvs_i  (dvs[s]),
      .rem_i  (rem[s]),
      .dvd_i  (dvd[s]),
      .quo_i  (quo[s]),
      .vld_o  (vld[s+1]),
      .side_o (side[s+1]),
      .dvs_o  (dvs[s+1]),
      .rem_o  (rem[s+1]),
      .dvd_o  (dvd[s+1]),
      .quo_o  (quo[s+1])
    );
  end

  assign vld_o  = vld[STEPS];
  assign side_o = side[STEPS];
  assign quo_o  = quo[STEPS];

endmodule

[rtl/core/stick_deadzone_edge_scaler_core.sv]
// Stick deadzone and edge scaler, top level: registers, pipeline stages and two divider chains.
// Depends on sdes_pkg and sdes_div_chain.
//
// A new request is taken in every clock cycle: busy is always low. Each request gives one
// result, shown for one cycle with out_valid high, after it passes through one input stage,
// 32 cells of the fraction divider, one limit stage, 17 cells of the limiting divider,
// one multiply stage and one output stage. Results leave in request order
// and cannot be held back by the receiver. Register writes take effect for requests taken
// after the write.
module stick_deadzone_edge_scaler_core #(
  parameter int FULL_SCALE = 32767
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_stick_x,
  input  logic [15:0] in_stick_y,
  // Result channel.
  output logic        out_valid,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW     = sdes_pkg::AXIS_W;
  localparam int LW     = sdes_pkg::LEVEL_W;
  localparam int NW     = sdes_pkg::NUM_W;
  localparam int FW     = sdes_pkg::FRAC_W;
  localparam int QW     = sdes_pkg::LIM_W;
  localparam int QB     = sdes_pkg::QBITS;
  localparam int FS_W   = $clog2(FULL_SCALE + 1);
  localparam int PROD_W = QW + FS_W;
  localparam int MAG_W  = PROD_W - QB;
  localparam int S1_W   = $bits(sdes_pkg::side1_t);
  localparam int S2_W   = $bits(sdes_pkg::side2_t);
  localparam logic [FS_W-1:0] FS_C = FS_W'(FULL_SCALE);

  // ---------------- Register port ----------------
  logic [LW-1:0] dead_r, dead_nxt;
  logic [LW-1:0] edge_r, edge_nxt;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // Register write decode.
  always_comb begin
    dead_nxt = dead_r;
    edge_nxt = edge_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        sdes_pkg::REG_DEAD: dead_nxt = pwdata[LW-1:0];
        sdes_pkg::REG_EDGE: edge_nxt = pwdata[LW-1:0];
        default:            dead_nxt = dead_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_r <= sdes_pkg::DEAD_RESET;
      edge_r <= sdes_pkg::EDGE_RESET;
    end else begin
      dead_r <= dead_nxt;
      edge_r <= edge_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      sdes_pkg::REG_DEAD: prdata = {{(32-LW){1'b0}}, dead_r};
      sdes_pkg::REG_EDGE: prdata = {{(32-LW){1'b0}}, edge_r};
      default:            prdata = '0;
    endcase
  end

  // ---------------- Input stage ----------------
  assign busy = 1'b0;

  logic            s0_vld_r;
  sdes_pkg::side1_t s0_side_r;
  logic [LW-1:0]   s0_span_r;
  logic [NW-1:0]   s0_nx_r, s0_ny_r;
  logic [AW:0]     abs_x, abs_y;
  logic [AW:0]     dead_ext;
  logic [AW:0]     diff_x, diff_y;

  // Magnitude above the deadzone, clamped at zero; -32768 counts as 32768.
  always_comb begin
    abs_x    = in_stick_x[AW-1] ? ((AW+1)'(0) - {in_stick_x[AW-1], in_stick_x})
                                : {1'b0, in_stick_x};
    abs_y    = in_stick_y[AW-1] ? ((AW+1)'(0) - {in_stick_y[AW-1], in_stick_y})
                                : {1'b0, in_stick_y};
    dead_ext = {{(AW+1-LW){1'b0}}, dead_r};
    diff_x   = abs_x - dead_ext;
    diff_y   = abs_y - dead_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_side_r.bypass <= edge_r <= dead_r;
    s0_side_r.raw_x  <= in_stick_x;
    s0_side_r.raw_y  <= in_stick_y;
    s0_span_r        <= edge_r - dead_r;
    s0_nx_r          <= (abs_x > dead_ext) ? diff_x[NW-1:0] : '0;
    s0_ny_r          <= (abs_y > dead_ext) ? diff_y[NW-1:0] : '0;
  end

  // ---------------- Fraction divider ----------------
  logic [1:0][LW-1:0] c1_dvs, c1_rem;
  logic [1:0][FW-1:0] c1_dvd, c1_quo;
  logic               c1_vld;
  logic [S1_W-1:0]    c1_side;

  // Lane 0 is x, lane 1 is y; both divide by the same span.
  assign c1_dvs[0] = s0_span_r;
  assign c1_dvs[1] = s0_span_r;
  assign c1_rem    = '0;
  assign c1_dvd[0] = {s0_nx_r, {QB{1'b0}}};
  assign c1_dvd[1] = {s0_ny_r, {QB{1'b0}}};

  sdes_div_chain #(
    .LANES  (2),
    .DVS_W  (LW),
    .STEPS  (FW),
    .SIDE_W (S1_W)
  ) u_frac_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s0_vld_r),
    .side_i (S1_W'(s0_side_r)),
    .dvs_i  (c1_dvs),
    .rem_i  (c1_rem),
    .dvd_i  (c1_dvd),
    .vld_o  (c1_vld),
    .side_o (c1_side),
    .quo_o  (c1_quo)
  );

  // ---------------- Limit stage ----------------
  logic             s1_vld_r;
  sdes_pkg::side2_t s1_side_r;
  logic [FW-1:0]    s1_m_r, s1_other_r;
  logic             lim, x_max;

  always_comb begin
    lim   = (c1_quo[0] > sdes_pkg::QONE) || (c1_quo[1] > sdes_pkg::QONE);
    x_max = c1_quo[0] >= c1_quo[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= c1_vld;
    end
  end

  // When a fraction exceeds one, the larger becomes one and the other is divided by it.
  always_ff @(posedge clk) begin
    s1_side_r.base  <= sdes_pkg::side1_t'(c1_side);
    s1_side_r.lim   <= lim;
    s1_side_r.x_max <= x_max;
    s1_side_r.fx    <= c1_quo[0][QW-1:0];
    s1_side_r.fy    <= c1_quo[1][QW-1:0];
    s1_m_r          <= x_max ? c1_quo[0] : c1_quo[1];
    s1_other_r      <= x_max ? c1_quo[1] : c1_quo[0];
  end

  // ---------------- Limiting divider ----------------
  logic [0:0][FW-1:0] c2_dvs, c2_rem;
  logic [0:0][QW-1:0] c2_dvd, c2_quo;
  logic               c2_vld;
  logic [S2_W-1:0]    c2_side;
  sdes_pkg::side2_t   c2_s;

  // The other fraction is at most the larger, so the quotient fits in 17 bits and
  // the upper dividend bits load straight into the remainder.
  assign c2_dvs[0] = s1_m_r;
  assign c2_rem[0] = {1'b0, s1_other_r[FW-1:1]};
  assign c2_dvd[0] = {s1_other_r[0], {QB{1'b0}}};

  sdes_div_chain #(
    .LANES  (1),
    .DVS_W  (FW),
    .STEPS  (QW),
    .SIDE_W (S2_W)
  ) u_lim_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s1_vld_r),
    .side_i (S2_W'(s1_side_r)),
    .dvs_i  (c2_dvs),
    .rem_i  (c2_rem),
    .dvd_i  (c2_dvd),
    .vld_o  (c2_vld),
    .side_o (c2_side),
    .quo_o  (c2_quo)
  );

  assign c2_s = sdes_pkg::side2_t'(c2_side);

  // ---------------- Multiply stage ----------------
  logic             s2_vld_r;
  sdes_pkg::side1_t s2_side_r;
  logic [PROD_W-1:0] s2_px_r, s2_py_r;
  logic [QW-1:0]    fin_x, fin_y;

  // Pick the final fractions.
  always_comb begin
    if (c2_s.lim) begin
      fin_x = c2_s.x_max ? sdes_pkg::QONE_LIM : c2_quo[0];
      fin_y = c2_s.x_max ? c2_quo[0] : sdes_pkg::QONE_LIM;
    end else begin
      fin_x = c2_s.fx;
      fin_y = c2_s.fy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= c2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r <= c2_s.base;
    s2_px_r   <= PROD_W'(fin_x) * PROD_W'(FS_C);
    s2_py_r   <= PROD_W'(fin_y) * PROD_W'(FS_C);
  end

  // ---------------- Output stage ----------------
  logic              out_valid_r;
  logic [AW-1:0]     out_x_r, out_y_r;
  logic [AW-1:0]     out_x_nxt, out_y_nxt;
  logic [MAG_W-1:0]  mag_xw, mag_yw;
  logic [AW-1:0]     mag_x, mag_y;

  // Drop the fraction bits, restore the sign, or pass the raw sample in bypass.
  always_comb begin
    mag_xw = s2_px_r[PROD_W-1:QB];
    mag_yw = s2_py_r[PROD_W-1:QB];
    mag_x  = AW'(mag_xw);
    mag_y  = AW'(mag_yw);
    if (s2_side_r.bypass) begin
      out_x_nxt = s2_side_r.raw_x;
      out_y_nxt = s2_side_r.raw_y;
    end else begin
      if (s2_side_r.raw_x == '0) begin
        out_x_nxt = '0;
      end else if (s2_side_r.raw_x[AW-1]) begin
        out_x_nxt = AW'(0) - mag_x;
      end else begin
        out_x_nxt = mag_x;
      end
      if (s2_side_r.raw_y == '0) begin
        out_y_nxt = '0;
      end else if (s2_side_r.raw_y[AW-1]) begin
        out_y_nxt = AW'(0) - mag_y;
      end else begin
        out_y_nxt = mag_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;

endmodule
